/* src/dosp_pkg.sv */
// Package: types and constants for the delta operation stream parser.
`timescale 1ns / 1ps
`default_nettype none

package dosp_pkg;

  localparam int unsigned OffsetBytes = 8;
  localparam int unsigned LengthBytes = 4;
  localparam int unsigned OutDepth    = 4;

  localparam logic [2:0] OffsetLastIdx = 3'(OffsetBytes - 1);
  localparam logic [1:0] LengthLastIdx = 2'(LengthBytes - 1);

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_COPY_OFF = 3'd1,
    PH_COPY_LEN = 3'd2,
    PH_INS_LEN  = 3'd3,
    PH_INS_PAY  = 3'd4
  } phase_e;

  typedef enum logic [1:0] {
    KIND_COPY      = 2'd0,
    KIND_INS_HDR   = 2'd1,
    KIND_INS_BYTE  = 2'd2,
    KIND_TRUNCATED = 2'd3
  } kind_e;

  typedef struct packed {
    logic [7:0] stream_byte;
    logic       buffer_end;
  } in_word_t;

  typedef struct packed {
    kind_e       kind;
    logic [63:0] src_offset;
    logic [31:0] span_length;
    logic [7:0]  payload_byte;
    logic        record_end;
    logic        run_last;
  } out_word_t;

endpackage

`default_nettype wire

/* src/delta_op_stream_parser_top.sv */
// Top level: delta operation stream parser with a small result queue.
`timescale 1ns / 1ps
`default_nettype none

// Decodes a byte stream of copy/insert delta operations, one byte per word.
// Input channel: in_word_i carries one stream byte and a buffer-end flag;
// a word moves when in_valid_i is high and in_stall_o is low.
// Output channel: out_word_o carries one decoded result; it moves when
// out_valid_o is high and out_stall_i is low.
// Configuration: cfg_we_i writes cfg_wdata_i into the copy opcode register.
// Each accepted byte updates the parse state in the cycle it is taken and
// pushes zero, one or two results into a four-entry result queue; the
// results are registered there and leave it in order at the output.
// The parser takes one byte per cycle while in_stall_o is low. A byte that
// produces two results (a header or payload byte followed by a truncation)
// sends them out one by one, so the output port sets the long-run rate:
// one result per cycle while out_stall_i is low. The input stalls while
// the queue holds more than two words, leaving room for the largest burst
// of one byte, so a stalled receiver backs up into the input after at most
// four queued results. Reset clears the parse state to idle, empties the
// queue and sets the copy opcode to zero.
module delta_op_stream_parser_top
  import dosp_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      cfg_we_i,
  input  wire logic [7:0] cfg_wdata_i,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire in_word_t  in_word_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output out_word_t      out_word_o
);

  localparam int unsigned PtrW = $clog2(OutDepth);
  localparam int unsigned CntW = $clog2(OutDepth + 1);

  logic [7:0]  copy_code_q;
  phase_e      phase_q, phase_d;
  logic [2:0]  fcnt_q, fcnt_d;
  logic [63:0] off_q, off_d;
  logic [31:0] len_q, len_d;
  logic [31:0] rem_q, rem_d;
  logic [31:0] len_new;

  out_word_t   queue_q [OutDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  out_word_t   res0, res1;
  logic [1:0]  n_res;
  logic        accept, pop;
  logic [7:0]  b;
  logic        buf_end;

  assign b       = in_word_i.stream_byte;
  assign buf_end = in_word_i.buffer_end;

  assign in_stall_o  = (count_q > CntW'(OutDepth - 2));
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = (count_q != '0);
  assign pop         = out_valid_o && !out_stall_i;
  assign out_word_o  = queue_q[rd_ptr_q];

  // Length field with the current byte dropped into its lane.
  always_comb begin
    len_new = len_q;
    len_new[{fcnt_q[1:0], 3'b000} +: 8] = b;
  end

  // Next parse state
  always_comb begin
    phase_d = phase_q;
    fcnt_d  = fcnt_q;
    off_d   = off_q;
    len_d   = len_q;
    rem_d   = rem_q;
    if (accept) begin
      unique case (phase_q)
        PH_COPY_OFF: begin
          off_d[{fcnt_q, 3'b000} +: 8] = b;
          fcnt_d = fcnt_q + 3'd1;
          if (fcnt_q == OffsetLastIdx) begin
            phase_d = PH_COPY_LEN;
            fcnt_d  = '0;
          end
        end
        PH_COPY_LEN: begin
          len_d  = len_new;
          fcnt_d = fcnt_q + 3'd1;
          if (fcnt_q[1:0] == LengthLastIdx) begin
            phase_d = PH_IDLE;
            fcnt_d  = '0;
            off_d   = '0;
            len_d   = '0;
            rem_d   = '0;
          end
        end
        PH_INS_LEN: begin
          len_d  = len_new;
          fcnt_d = fcnt_q + 3'd1;
          if (fcnt_q[1:0] == LengthLastIdx) begin
            fcnt_d = '0;
            if (len_new == '0) begin
              phase_d = PH_IDLE;
              off_d   = '0;
              len_d   = '0;
              rem_d   = '0;
            end else begin
              phase_d = PH_INS_PAY;
              rem_d   = len_new;
            end
          end
        end
        PH_INS_PAY: begin
          if (rem_q <= 32'd1) begin
            phase_d = PH_IDLE;
            fcnt_d  = '0;
            off_d   = '0;
            len_d   = '0;
            rem_d   = '0;
          end else begin
            rem_d = rem_q - 32'd1;
          end
        end
        default: begin
          // Opcode byte; unused phase codes land here too.
          phase_d = (b == copy_code_q) ? PH_COPY_OFF : PH_INS_LEN;
          fcnt_d  = '0;
          off_d   = '0;
          len_d   = '0;
          rem_d   = '0;
        end
      endcase
      if (buf_end) begin
        phase_d = PH_IDLE;
        fcnt_d  = '0;
        off_d   = '0;
        len_d   = '0;
        rem_d   = '0;
      end
    end
  end

  // Results of the current byte
  always_comb begin
    logic has0;
    logic done;
    res0  = '0;
    res1  = '0;
    has0  = 1'b0;
    done  = 1'b0;
    n_res = 2'd0;
    unique case (phase_q)
      PH_COPY_LEN: begin
        if (fcnt_q[1:0] == LengthLastIdx) begin
          res0.kind        = KIND_COPY;
          res0.src_offset  = off_q;
          res0.span_length = len_new;
          res0.record_end  = 1'b1;
          has0 = 1'b1;
          done = 1'b1;
        end
      end
      PH_INS_LEN: begin
        if (fcnt_q[1:0] == LengthLastIdx) begin
          res0.kind        = KIND_INS_HDR;
          res0.span_length = len_new;
          res0.record_end  = (len_new == '0);
          has0 = 1'b1;
          done = (len_new == '0);
        end
      end
      PH_INS_PAY: begin
        res0.kind         = KIND_INS_BYTE;
        res0.span_length  = len_q;
        res0.payload_byte = b;
        res0.record_end   = (rem_q <= 32'd1);
        has0 = 1'b1;
        done = (rem_q <= 32'd1);
      end
      default: begin
        has0 = 1'b0;
      end
    endcase

    if (buf_end && !done) begin
      // Append the truncation result behind any other result of this byte.
      if (has0) begin
        res1.kind       = KIND_TRUNCATED;
        res1.record_end = 1'b1;
        res1.run_last   = 1'b1;
        n_res = 2'd2;
      end else begin
        res0.kind       = KIND_TRUNCATED;
        res0.record_end = 1'b1;
        res0.run_last   = 1'b1;
        n_res = 2'd1;
      end
    end else if (has0) begin
      res0.run_last = 1'b1;
      n_res = 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      copy_code_q <= '0;
      phase_q     <= PH_IDLE;
      fcnt_q      <= '0;
      off_q       <= '0;
      len_q       <= '0;
      rem_q       <= '0;
      wr_ptr_q    <= '0;
      rd_ptr_q    <= '0;
      count_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        copy_code_q <= cfg_wdata_i;
      end
      phase_q <= phase_d;
      fcnt_q  <= fcnt_d;
      off_q   <= off_d;
      len_q   <= len_d;
      rem_q   <= rem_d;
      if (accept) begin
        wr_ptr_q <= wr_ptr_q + PtrW'(n_res);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      count_q <= count_q + (accept ? CntW'(n_res) : CntW'(0)) - (pop ? CntW'(1) : CntW'(0));
    end
  end

  // Result queue storage
  always_ff @(posedge clk_i) begin
    if (accept && (n_res != 2'd0)) begin
      queue_q[wr_ptr_q] <= res0;
    end
    if (accept && (n_res == 2'd2)) begin
      queue_q[wr_ptr_q + PtrW'(1)] <= res1;
    end
  end

endmodule

`default_nettype wire
